### rtl/core/lruc_pkg.sv
// ============================================================================
// lruc_pkg
// Shared types and constants for the lru key-value cache: request and result
// payloads, operation codes and the capacity register format.
// ============================================================================
package lruc_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } lruc_req_t;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] value_out;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
    } lruc_rsp_t;

endpackage

### rtl/core/lru_key_value_cache_unit.sv
// ============================================================================
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ============================================================================
// A request transfers on a rising edge with start high and busy low. A get
// returns the stored value on a hit and refreshes the entry; a put updates a
// present key or inserts a new one, evicting the least recent entry once the
// number of entries in use reaches the capacity, clamped to 1..ENTRIES.
// Keys and values sit in two single-port synchronous memories; valid bits
// and recency ranks sit in flops. Each request sweeps the key memory one
// entry per cycle, then drains the read pipeline and commits the writes and
// rank updates; busy is high from the scan through the commit state, and
// the next request can transfer only once it falls. done is registered from
// the commit state and stays high for exactly one cycle, so the result
// transfers on the same edge as the earliest next request; the receiver has
// no way to stall it. The user must see that the capacity register is
// written with cfg_wr_en only while no request is in flight; the block does
// not enforce this itself. Reset empties the cache at once (valid bits
// cleared) and sets the capacity to 16; the memories themselves are not
// cleared.
// ============================================================================
module lru_key_value_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lruc_pkg::lruc_req_t        request,
    output logic                       done,
    output lruc_pkg::lruc_rsp_t        result,
    input  logic                       cfg_wr_en,
    input  logic [lruc_pkg::CAP_W-1:0] cfg_wr_data
);
    import lruc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    // storage
    logic [KEY_W-1:0]   key_mem [ENTRIES];
    logic [VALUE_W-1:0] val_mem [ENTRIES];
    logic [KEY_W-1:0]   rd_key;
    logic [VALUE_W-1:0] rd_val;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]   rank_reg [ENTRIES];
    logic [IDX_W-1:0]   rank_next [ENTRIES];
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;

    // control
    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             done_reg, done_next;

    // request held for the sweep
    logic               op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VALUE_W-1:0] val_reg, val_next;

    // sweep results
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_slot_reg, hit_slot_next;
    logic [IDX_W-1:0]   hit_rank_reg, hit_rank_next;
    logic [VALUE_W-1:0] hit_val_reg, hit_val_next;
    logic [IDX_W-1:0]   lru_slot_reg, lru_slot_next;
    logic [KEY_W-1:0]   lru_key_reg, lru_key_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_slot_reg, free_slot_next;

    lruc_rsp_t result_reg, result_next;

    logic             accept;
    logic             ent_valid;
    logic [IDX_W-1:0] ent_rank;
    logic             match_w;
    logic             lru_w;
    logic             free_w;
    logic             commit;
    logic             is_put;
    logic             ins;
    logic             full;
    logic             evict;
    logic [CMP_W-1:0] cap_eff;
    logic [IDX_W-1:0] tgt_slot;
    logic             key_we;
    logic             val_we;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign accept = start && !busy;
    assign commit = (state_reg == ST_COMMIT);

    // entry arriving from the memories this cycle
    assign ent_valid = valid_reg[rd_idx_reg];
    assign ent_rank  = rank_reg[rd_idx_reg];
    assign match_w   = rd_vld_reg && ent_valid && (rd_key == key_reg);
    assign lru_w     = rd_vld_reg && ent_valid
                       && ((OCC_W'(ent_rank) + OCC_W'(1)) == occ_reg);
    assign free_w    = rd_vld_reg && !ent_valid && !free_found_reg;

    // commit decisions
    always_comb
    begin
        cap_eff = CMP_W'(cap_reg);
        if (cap_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_eff > ENTRIES_C)
        begin
            cap_eff = ENTRIES_C;
        end
    end

    assign is_put = (op_reg == OP_PUT);
    assign ins    = is_put && !hit_reg;
    assign full   = (CMP_W'(occ_reg) >= cap_eff);
    assign evict  = ins && full;

    always_comb
    begin
        if (hit_reg)
        begin
            tgt_slot = hit_slot_reg;
        end
        else if (full)
        begin
            tgt_slot = lru_slot_reg;
        end
        else
        begin
            tgt_slot = free_slot_reg;
        end
    end

    assign key_we = commit && ins;
    assign val_we = commit && is_put;

    // key and value memories
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[tgt_slot] <= key_reg;
        end
        else
        begin
            rd_key <= key_mem[addr_reg];
        end
        if (val_we)
        begin
            val_mem[tgt_slot] <= val_reg;
        end
        else
        begin
            rd_val <= val_mem[addr_reg];
        end
    end

    // sequencer and sweep capture
    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        rd_vld_next     = (state_reg == ST_SCAN);
        rd_idx_next     = addr_reg;
        done_next       = commit;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        hit_rank_next   = hit_rank_reg;
        hit_val_next    = hit_val_reg;
        lru_slot_next   = lru_slot_reg;
        lru_key_next    = lru_key_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next      = ST_SCAN;
                    addr_next       = '0;
                    op_next         = request.operation;
                    key_next        = request.key;
                    val_next        = request.value;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (match_w)
        begin
            hit_next      = 1'b1;
            hit_slot_next = rd_idx_reg;
            hit_rank_next = ent_rank;
            hit_val_next  = rd_val;
        end
        if (lru_w)
        begin
            lru_slot_next = rd_idx_reg;
            lru_key_next  = rd_key;
        end
        if (free_w)
        begin
            free_found_next = 1'b1;
            free_slot_next  = rd_idx_reg;
        end
    end

    // recency, occupancy and capacity
    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        cap_next   = cfg_wr_en ? cfg_wr_data : cap_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (commit && (hit_reg || ins))
            begin
                if (IDX_W'(i) == tgt_slot)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (ins || (rank_reg[i] < hit_rank_reg)))
                begin
                    // entries more recent than the touched one age by one
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
        end
        if (commit && ins)
        begin
            valid_next[tgt_slot] = 1'b1;
            if (!full)
            begin
                occ_next = occ_reg + OCC_W'(1);
            end
        end
    end

    always_comb
    begin
        result_next             = result_reg;
        if (commit)
        begin
            result_next.found       = hit_reg;
            result_next.value_out   = (!is_put && hit_reg) ? hit_val_reg : '0;
            result_next.evicted     = evict;
            result_next.evicted_key = evict ? lru_key_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            addr_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            occ_reg        <= '0;
            cap_reg        <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            rd_vld_reg     <= rd_vld_next;
            done_reg       <= done_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            cap_reg        <= cap_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        op_reg        <= op_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        hit_slot_reg  <= hit_slot_next;
        hit_rank_reg  <= hit_rank_next;
        hit_val_reg   <= hit_val_next;
        lru_slot_reg  <= lru_slot_next;
        lru_key_reg   <= lru_key_next;
        free_slot_reg <= free_slot_next;
        result_reg    <= result_next;
    end

    // checks
    a_occ_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy differs from number of valid entries");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        match_w |-> !hit_reg)
        else $error("key stored in more than one entry");

    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_COMMIT)
        else $error("result strobe without a commit cycle");

    a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("request finished without a result transfer");

    a_evict_only_put_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.evicted |-> !result.found && $past(op_reg) == OP_PUT)
        else $error("eviction reported outside a put miss");

endmodule

### test/lru_key_value_cache_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// lru_key_value_cache_unit_tb
// Self-checking bench for the lru key-value cache. A directed table runs
// first: misses after reset, extreme keys and values, put hits, and capacity
// changes to zero, one, above the entry count and below the occupancy. Random
// phases follow, each with its own capacity and key pool, so that hits,
// updates and evictions are frequent. An in-bench predictor tracks contents and
// recency; results are checked in order, field by field, against it or the table.
// ============================================================================
module lru_key_value_cache_unit_tb;

    import lruc_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PHASES  = 15;
    localparam int PHASE_ITEMS = 70;
    localparam int NUM_ROWS    = 19;

    localparam lruc_rsp_t RSP_NONE    = '0;
    localparam lruc_rsp_t RSP_PUT_HIT = '{1'b1, 32'h0, 1'b0, 32'h0};

    typedef struct packed {
        logic             cfg_first;
        logic [CAP_W-1:0] cfg_val;
        lruc_req_t        req;
        logic             typed;
        lruc_rsp_t        rsp;
    } dir_row_t;

    // typed results are the ones obvious from the sequence; others use the predictor
    localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{1'b0, 5'd0,  '{OP_GET, 32'h0000_0000, 32'h0000_0000}, 1'b1, RSP_NONE},
        '{1'b0, 5'd0,  '{OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, RSP_NONE},
        '{1'b0, 5'd0,  '{OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, RSP_NONE},
        '{1'b0, 5'd0,  '{OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, RSP_NONE},
        '{1'b0, 5'd0,  '{OP_GET, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
        '{1'b0, 5'd0,  '{OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{1'b1, 32'h0000_0000, 1'b0, 32'h0}},
        '{1'b0, 5'd0,  '{OP_PUT, 32'h0000_0000, 32'h1234_5678}, 1'b1, RSP_PUT_HIT},
        '{1'b0, 5'd0,  '{OP_GET, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
          '{1'b1, 32'h1234_5678, 1'b0, 32'h0}},
        // capacity lowered below occupancy: one eviction per absent put
        '{1'b1, 5'd1,  '{OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b1,
          '{1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF}},
        '{1'b0, 5'd0,  '{OP_PUT, 32'hBBBB_BBBB, 32'h0000_0001}, 1'b1,
          '{1'b0, 32'h0, 1'b1, 32'h0000_0000}},
        '{1'b0, 5'd0,  '{OP_GET, 32'hAAAA_AAAA, 32'h0000_0000}, 1'b1,
          '{1'b1, 32'h5555_5555, 1'b0, 32'h0}},
        // capacity zero acts as one
        '{1'b1, 5'd0,  '{OP_PUT, 32'h0000_0001, 32'h8000_0000}, 1'b1,
          '{1'b0, 32'h0, 1'b1, 32'hBBBB_BBBB}},
        '{1'b0, 5'd0,  '{OP_PUT, 32'h0000_0001, 32'h7FFF_FFFF}, 1'b1, RSP_PUT_HIT},
        // capacity above the entry count acts as the entry count
        '{1'b1, 5'd31, '{OP_PUT, 32'h0000_0002, 32'h0000_0000}, 1'b0, RSP_NONE},
        '{1'b1, 5'd3,  '{OP_PUT, 32'h0000_0003, 32'h0000_0003}, 1'b0, RSP_NONE},
        '{1'b0, 5'd0,  '{OP_GET, 32'h0000_0001, 32'h0000_0000}, 1'b0, RSP_NONE},
        '{1'b0, 5'd0,  '{OP_PUT, 32'h0000_0004, 32'hDEAD_BEEF}, 1'b0, RSP_NONE},
        '{1'b0, 5'd0,  '{OP_GET, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, RSP_NONE},
        '{1'b0, 5'd0,  '{OP_GET, 32'h0000_0003, 32'h0000_0000}, 1'b0, RSP_NONE}
    };

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    lruc_req_t        request     = '0;
    logic             done;
    lruc_rsp_t        result;
    logic             cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;

    lru_key_value_cache_unit #(
        .ENTRIES(ENTRIES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predicted cache contents
    logic [KEY_W-1:0]   model_key   [ENTRIES];
    logic [VALUE_W-1:0] model_value [ENTRIES];
    bit                 model_valid [ENTRIES];
    int                 model_rank  [ENTRIES];
    int                 model_occupancy;
    logic [CAP_W-1:0]   model_capacity;

    lruc_rsp_t pending_results[$];
    lruc_rsp_t oldest_result;

    int mismatch_count = 0;
    int stall_cycles   = 0;
    int n_gets         = 0;
    int n_puts         = 0;
    int n_hits         = 0;
    int n_evictions    = 0;
    int n_cfg_writes   = 0;

    function automatic void make_most_recent(input int slot);
        int old_rank;
        old_rank = model_rank[slot];
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (model_valid[i] && i != slot && model_rank[i] < old_rank)
                model_rank[i]++;
        end
        model_rank[slot] = 0;
    endfunction

    function automatic lruc_rsp_t predict_access(input lruc_req_t req);
        lruc_rsp_t rsp;
        int        hit_slot;
        int        slot;
        int        worst;
        int        eff_cap;
        rsp      = '0;
        hit_slot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_slot < 0 && model_valid[i] && model_key[i] == req.key)
                hit_slot = i;
        end
        eff_cap = (model_capacity == 0) ? 1 : int'(model_capacity);
        if (eff_cap > ENTRIES)
            eff_cap = ENTRIES;

        if (req.operation == OP_GET)
        begin
            n_gets++;
            if (hit_slot >= 0)
            begin
                rsp.found     = 1'b1;
                rsp.value_out = model_value[hit_slot];
                make_most_recent(hit_slot);
            end
        end
        else if (hit_slot >= 0)
        begin
            n_puts++;
            rsp.found              = 1'b1;
            model_value[hit_slot]  = req.value;
            make_most_recent(hit_slot);
        end
        else
        begin
            n_puts++;
            slot  = -1;
            worst = 0;
            if (model_occupancy >= eff_cap)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (model_valid[i] && (slot < 0 || model_rank[i] > worst))
                    begin
                        slot  = i;
                        worst = model_rank[i];
                    end
                end
            end
            if (slot >= 0)
            begin
                rsp.evicted     = 1'b1;
                rsp.evicted_key = model_key[slot];
            end
            else
            begin
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (!model_valid[i])
                        slot = i;
                end
                model_occupancy++;
            end
            // reused or new slot enters as oldest, then moves to the front
            model_valid[slot] = 1'b1;
            model_rank[slot]  = model_occupancy;
            model_key[slot]   = req.key;
            model_value[slot] = req.value;
            make_most_recent(slot);
        end
        if (rsp.found)
            n_hits++;
        if (rsp.evicted)
            n_evictions++;
        return rsp;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 80);
    endfunction

    // holds start until the request transfers, then records the expectation
    task automatic issue_request(input lruc_req_t req, input bit typed,
                                 input lruc_rsp_t typed_rsp);
        lruc_rsp_t predicted;
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_access(req);
        if (typed)
            pending_results.push_back(typed_rsp);
        else
            pending_results.push_back(predicted);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        model_capacity  = cap;
        n_cfg_writes++;
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items);
        logic [KEY_W-1:0] key_pool [24];
        int               pool_size;
        int               put_pct;
        bit               no_idle;
        lruc_req_t        req;
        write_capacity(cap);
        pool_size = $urandom_range(1, 24);
        put_pct   = $urandom_range(30, 70);
        no_idle   = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 24; i++)
            key_pool[i] = $urandom;
        key_pool[0] = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        for (int n = 0; n < n_items; n++)
        begin
            req.operation = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET;
            if ($urandom_range(0, 9) == 0)
                req.key = $urandom;
            else
                req.key = key_pool[$urandom_range(0, pool_size - 1)];
            req.value = $urandom;
            issue_request(req, 1'b0, RSP_NONE);
            if ($urandom_range(0, 49) == 0)
                wait_drained();
            else if (!no_idle)
                idle_sender(pick_gap());
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: found=%0b value_out=%h evicted=%0b key=%h",
                             result.found, result.value_out, result.evicted,
                             result.evicted_key);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (result.found !== oldest_result.found ||
                    result.value_out !== oldest_result.value_out ||
                    result.evicted !== oldest_result.evicted ||
                    result.evicted_key !== oldest_result.evicted_key)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp found=%0b value_out=%h evicted=%0b key=%h,",
                                  " got found=%0b value_out=%h evicted=%0b key=%h"},
                                 oldest_result.found, oldest_result.value_out,
                                 oldest_result.evicted, oldest_result.evicted_key,
                                 result.found, result.value_out, result.evicted,
                                 result.evicted_key);
                end
            end
        end
    end

    // watchdog: cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles < STALL_LIMIT)
            stall_cycles <= stall_cycles + 1;
        else
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("lru_key_value_cache_unit_tb: errors");
            $finish;
        end
    end

    logic [CAP_W-1:0] phase_caps [NUM_PHASES];

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            model_key[i]   = '0;
            model_value[i] = '0;
            model_valid[i] = 1'b0;
            model_rank[i]  = 0;
        end
        model_occupancy = 0;
        model_capacity  = CAP_RESET;
        phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd2, 5'd8,
                       5'd30, 5'd15, 5'd3, 5'd0, 5'd0, 5'd16, 5'd6};
        phase_caps[11] = CAP_W'($urandom_range(0, 31));
        phase_caps[12] = CAP_W'($urandom_range(1, 16));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED_ROWS[r].cfg_first)
                write_capacity(DIRECTED_ROWS[r].cfg_val);
            issue_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].typed,
                          DIRECTED_ROWS[r].rsp);
            idle_sender(pick_gap());
        end

        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(phase_caps[p], PHASE_ITEMS);

        wait_drained();
        repeat (2 * (ENTRIES + 3)) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d results never arrived", pending_results.size());
            mismatch_count += pending_results.size();
        end

        $display("covered %0d requests (%0d gets, %0d puts): %0d hits, %0d evictions",
                 n_gets + n_puts, n_gets, n_puts, n_hits, n_evictions);
        $display("%0d capacity writes over %0d random phases, %0d mismatches",
                 n_cfg_writes, NUM_PHASES, mismatch_count);
        if (mismatch_count == 0)
            $display("lru_key_value_cache_unit_tb: clean");
        else
            $display("lru_key_value_cache_unit_tb: errors");
        $finish;
    end

endmodule
